// File: rtl/mrst_pkg.sv
// ----------------------------------------------------------------------------
// mrst_pkg
// Shared widths, defaults and the stored edge record of the maximum-ratio
// spanning tree search.
// ----------------------------------------------------------------------------
package mrst_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 256;
  localparam int DEF_FRAC_BITS = 16;

  localparam int END_W = 6;
  localparam int WT_W  = 16;
  localparam int TOT_W = 22;
  localparam int CFG_W = 7;
  localparam int MIN_NODES = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

  // One stored edge
  typedef struct packed {
    logic [END_W-1:0] a;
    logic [END_W-1:0] b;
    logic [WT_W-1:0]  d;
    logic [WT_W-1:0]  r;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

endpackage

// File: rtl/mrst_ram.sv
// ----------------------------------------------------------------------------
// mrst_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module mrst_ram #(
  parameter int W     = mrst_pkg::EDGE_W,
  parameter int DEPTH = mrst_pkg::DEF_MAX_EDGES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/max_ratio_spanning_tree.sv
// ----------------------------------------------------------------------------
// max_ratio_spanning_tree
// Loads a graph's edges, binary-searches the best sum(d)/sum(r) spanning tree
// with Kruskal probes and reports its D and R totals.
// ----------------------------------------------------------------------------
// Edges load one per cycle into the edge RAM while the block is idle. The
// item marked last starts a search that accepts no items until its result
// is registered: about log2(sum(r) * 2^(FRAC_BITS-1)) probes. Each probe first
// computes a key for every edge (read, multiply, write) and then resets the
// union-find RAM entry of each node. Each edge that Kruskal examines costs a
// selection pass over the edge and key RAMs, plus a read and a check per
// union-find step and a write of the hung root and of the new root's size to
// join two sets. The selection pass and the single read port of each RAM set a
// probe's time.
module max_ratio_spanning_tree #(
  parameter int MAX_NODES = mrst_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = mrst_pkg::DEF_MAX_EDGES,
  parameter int FRAC_BITS = mrst_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mrst_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mrst_pkg::END_W-1:0] in_end_a,
  input  logic [mrst_pkg::END_W-1:0] in_end_b,
  input  logic [mrst_pkg::WT_W-1:0]  in_gain_weight,
  input  logic [mrst_pkg::WT_W-1:0]  in_cost_weight,
  input  logic                       in_last_edge,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_impossible,
  output logic [mrst_pkg::TOT_W-1:0] out_best_gain_total,
  output logic [mrst_pkg::TOT_W-1:0] out_best_cost_total
);

  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int NW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int WT_W = mrst_pkg::WT_W;
  localparam int SUMW = WT_W + CW;
  localparam int RW   = SUMW + FRAC_BITS;
  localparam int PW   = RW + WT_W;
  localparam int KW   = PW + 1;
  localparam int DW   = WT_W + NCW;
  localparam int FW   = RW + DW;
  localparam int XW   = 2 * DW;
  localparam int TW   = mrst_pkg::TOT_W;
  localparam int DSW  = NW + NCW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_KRD   = 5'd2;
  localparam logic [4:0] S_KMUL  = 5'd3;
  localparam logic [4:0] S_KWR   = 5'd4;
  localparam logic [4:0] S_DINIT = 5'd5;
  localparam logic [4:0] S_NXT   = 5'd6;
  localparam logic [4:0] S_SCAN  = 5'd7;
  localparam logic [4:0] S_SDRN  = 5'd8;
  localparam logic [4:0] S_SSEL  = 5'd9;
  localparam logic [4:0] S_FRD   = 5'd10;
  localparam logic [4:0] S_FCHK  = 5'd11;
  localparam logic [4:0] S_UNI   = 5'd12;
  localparam logic [4:0] S_UWR   = 5'd13;
  localparam logic [4:0] S_EMUL  = 5'd14;
  localparam logic [4:0] S_EDEC  = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;

  // Edge record as ranked within one probe
  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [WT_W-1:0]      d;
    logic [WT_W-1:0]      r;
    logic [mrst_pkg::END_W-1:0] a;
    logic [mrst_pkg::END_W-1:0] b;
    logic [EW-1:0]        idx;
  } rank_t;

  // True when x is taken before y
  function automatic logic goes_first(rank_t x, rank_t y);
    logic res;
    if (x.key != y.key)    res = x.key > y.key;
    else if (x.d != y.d)   res = x.d < y.d;
    else if (x.r != y.r)   res = x.r > y.r;
    else if (x.a != y.a)   res = x.a > y.a;
    else if (x.b != y.b)   res = x.b > y.b;
    else                   res = x.idx < y.idx;
    return res;
  endfunction

  logic [4:0]           state_r, state_nxt;
  logic [mrst_pkg::CFG_W-1:0] cfg_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SUMW-1:0]      sum_r, sum_nxt;
  logic [RW-1:0]        low_r, low_nxt, high_r, high_nxt, mid_r, mid_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [NCW-1:0]       nidx_r, nidx_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic                 pend_r, pend_nxt;
  logic [EW-1:0]        cidx_r, cidx_nxt;
  rank_t                sel_r, sel_nxt, prev_r, prev_nxt;
  logic                 sel_v_r, sel_v_nxt, prev_v_r, prev_v_nxt;
  logic [NW-1:0]        cur_r, cur_nxt, ru_r, ru_nxt, rv_r, rv_nxt;
  logic [NCW-1:0]       su_r, su_nxt, sv_r, sv_nxt;
  logic                 which_r, which_nxt;
  logic [NCW-1:0]       taken_r, taken_nxt;
  logic [DW-1:0]        dsum_r, dsum_nxt, rsum_r, rsum_nxt;
  logic [FW-1:0]        fprod_r, fprod_nxt;
  logic [XW-1:0]        x1_r, x1_nxt, x2_r, x2_nxt;
  logic                 found_r, found_nxt;
  logic [DW-1:0]        bd_r, bd_nxt, br_r, br_nxt;
  logic                 ov_r, ov_nxt, oimp_r, oimp_nxt;
  logic [TW-1:0]        og_r, og_nxt, oc_r, oc_nxt;

  logic [NCW-1:0]       n_used, n1;
  logic                 accept;

  // Edge RAM ports
  logic                 e_we, e_re;
  logic [EW-1:0]        e_waddr, e_raddr;
  mrst_pkg::edge_t      e_wdata, e_rd;
  // Key RAM ports
  logic                 k_we, k_re;
  logic [EW-1:0]        k_waddr;
  logic signed [KW-1:0] k_wdata, k_rd;
  // Union-find RAM ports: {parent, size}
  logic                 u_we, u_re;
  logic [NW-1:0]        u_waddr, u_raddr;
  logic [DSW-1:0]       u_wdata, u_rd;

  rank_t                cand;
  logic [RW:0]          mid_sum;
  logic [DW+TW-1:0]     gext, cext;

  mrst_ram #(.W(mrst_pkg::EDGE_W), .DEPTH(MAX_EDGES), .AW(EW)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rd)
  );

  mrst_ram #(.W(KW), .DEPTH(MAX_EDGES), .AW(EW)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(e_raddr), .rdata(k_rd)
  );

  mrst_ram #(.W(DSW), .DEPTH(MAX_NODES), .AW(NW)) u_dsu_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .re(u_re), .raddr(u_raddr), .rdata(u_rd)
  );

  // Clamp the node count
  always_comb begin
    int unsigned c;
    c = 32'(cfg_r);
    if (c < mrst_pkg::MIN_NODES) c = mrst_pkg::MIN_NODES;
    else if (c > MAX_NODES) c = MAX_NODES;
    n_used = NCW'(c);
    n1     = NCW'(c - 1);
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign mid_sum  = {1'b0, low_r} + {1'b0, high_r};

  assign cand.key = k_rd;
  assign cand.d   = e_rd.d;
  assign cand.r   = e_rd.r;
  assign cand.a   = e_rd.a;
  assign cand.b   = e_rd.b;
  assign cand.idx = cidx_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    mid_nxt    = mid_r;
    idx_nxt    = idx_r;
    nidx_nxt   = nidx_r;
    prod_nxt   = prod_r;
    pend_nxt   = 1'b0;
    cidx_nxt   = cidx_r;
    sel_nxt    = sel_r;
    sel_v_nxt  = sel_v_r;
    prev_nxt   = prev_r;
    prev_v_nxt = prev_v_r;
    cur_nxt    = cur_r;
    ru_nxt     = ru_r;
    rv_nxt     = rv_r;
    su_nxt     = su_r;
    sv_nxt     = sv_r;
    which_nxt  = which_r;
    taken_nxt  = taken_r;
    dsum_nxt   = dsum_r;
    rsum_nxt   = rsum_r;
    fprod_nxt  = fprod_r;
    x1_nxt     = x1_r;
    x2_nxt     = x2_r;
    found_nxt  = found_r;
    bd_nxt     = bd_r;
    br_nxt     = br_r;
    ov_nxt     = ov_r;
    oimp_nxt   = oimp_r;
    og_nxt     = og_r;
    oc_nxt     = oc_r;
    e_we    = 1'b0;
    e_waddr = cnt_r[EW-1:0];
    e_wdata = '{a: in_end_a, b: in_end_b, d: in_gain_weight, r: in_cost_weight};
    e_re    = 1'b0;
    e_raddr = idx_r[EW-1:0];
    k_we    = 1'b0;
    k_waddr = idx_r[EW-1:0];
    k_wdata = $signed({1'b0, PW'(e_rd.d) << FRAC_BITS}) - $signed({1'b0, prod_r});
    k_re    = 1'b0;
    u_we    = 1'b0;
    u_waddr = NW'(nidx_r);
    u_wdata = {NW'(nidx_r), NCW'(1)};
    u_re    = 1'b0;
    u_raddr = cur_r;
    gext    = {{TW{1'b0}}, bd_r};
    cext    = {{TW{1'b0}}, br_r};

    // Release the result register
    if (ov_r && out_ready) ov_nxt = 1'b0;

    // Compare the candidate read in the previous cycle
    if (pend_r && (!prev_v_r || goes_first(prev_r, cand))) begin
      if (!sel_v_r || goes_first(cand, sel_r)) begin
        sel_nxt   = cand;
        sel_v_nxt = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cnt_r < CW'(MAX_EDGES)) begin
            e_we    = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            sum_nxt = sum_r + SUMW'(in_cost_weight);
          end
          if (in_last_edge) begin
            low_nxt   = '0;
            high_nxt  = RW'({((cnt_r < CW'(MAX_EDGES)) ? sum_nxt : sum_r),
                             {FRAC_BITS{1'b0}}} >> 1);
            found_nxt = 1'b0;
            bd_nxt    = '0;
            br_nxt    = '0;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if ((high_r - low_r) > RW'(1)) begin
          mid_nxt   = mid_sum[RW:1];
          idx_nxt   = '0;
          state_nxt = S_KRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_KRD: begin
        e_re      = 1'b1;
        state_nxt = S_KMUL;
      end
      S_KMUL: begin
        prod_nxt  = mid_r * e_rd.r;
        state_nxt = S_KWR;
      end
      S_KWR: begin
        k_we    = 1'b1;
        idx_nxt = idx_r + CW'(1);
        if (idx_nxt == cnt_r) begin
          nidx_nxt  = '0;
          state_nxt = S_DINIT;
        end else begin
          state_nxt = S_KRD;
        end
      end
      S_DINIT: begin
        u_we     = 1'b1;
        nidx_nxt = nidx_r + NCW'(1);
        if (nidx_nxt == n_used) begin
          taken_nxt  = '0;
          dsum_nxt   = '0;
          rsum_nxt   = '0;
          prev_v_nxt = 1'b0;
          state_nxt  = S_NXT;
        end
      end
      S_NXT: begin
        if (taken_r == n1) begin
          state_nxt = S_EMUL;
        end else begin
          idx_nxt   = '0;
          sel_v_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        e_re     = 1'b1;
        k_re     = 1'b1;
        pend_nxt = 1'b1;
        cidx_nxt = idx_r[EW-1:0];
        idx_nxt  = idx_r + CW'(1);
        if (idx_nxt == cnt_r) state_nxt = S_SDRN;
      end
      S_SDRN: begin
        state_nxt = S_SSEL;
      end
      S_SSEL: begin
        if (!sel_v_r) begin
          state_nxt = S_EMUL;
        end else begin
          prev_nxt   = sel_r;
          prev_v_nxt = 1'b1;
          if (32'(sel_r.a) >= 32'(n_used) || 32'(sel_r.b) >= 32'(n_used)) begin
            state_nxt = S_NXT;
          end else begin
            cur_nxt   = NW'(sel_r.a);
            which_nxt = 1'b0;
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        u_re      = 1'b1;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (u_rd[DSW-1:NCW] == cur_r) begin
          if (!which_r) begin
            ru_nxt    = cur_r;
            su_nxt    = u_rd[NCW-1:0];
            cur_nxt   = NW'(prev_r.b);
            which_nxt = 1'b1;
            state_nxt = S_FRD;
          end else begin
            rv_nxt    = cur_r;
            sv_nxt    = u_rd[NCW-1:0];
            state_nxt = S_UNI;
          end
        end else begin
          cur_nxt   = u_rd[DSW-1:NCW];
          state_nxt = S_FRD;
        end
      end
      S_UNI: begin
        if (ru_r == rv_r) begin
          state_nxt = S_NXT;
        end else begin
          // Hang the smaller set under the larger one
          u_we = 1'b1;
          if (su_r < sv_r) begin
            u_waddr = ru_r;
            u_wdata = {rv_r, su_r};
            ru_nxt  = rv_r;
          end else begin
            u_waddr = rv_r;
            u_wdata = {ru_r, sv_r};
          end
          su_nxt    = su_r + sv_r;
          state_nxt = S_UWR;
        end
      end
      S_UWR: begin
        u_we      = 1'b1;
        u_waddr   = ru_r;
        u_wdata   = {ru_r, su_r};
        dsum_nxt  = dsum_r + DW'(prev_r.d);
        rsum_nxt  = rsum_r + DW'(prev_r.r);
        taken_nxt = taken_r + NCW'(1);
        state_nxt = S_NXT;
      end
      S_EMUL: begin
        fprod_nxt = mid_r * rsum_r;
        x1_nxt    = dsum_r * br_r;
        x2_nxt    = bd_r * rsum_r;
        state_nxt = S_EDEC;
      end
      S_EDEC: begin
        if (taken_r == n1 && (FW'(dsum_r) << FRAC_BITS) >= fprod_r) begin
          low_nxt = mid_r;
          if (!found_r || x1_r > x2_r) begin
            found_nxt = 1'b1;
            bd_nxt    = dsum_r;
            br_nxt    = rsum_r;
          end
        end else begin
          high_nxt = mid_r;
        end
        state_nxt = S_CHK;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oimp_nxt  = !found_r;
          og_nxt    = found_r ? gext[TW-1:0] : '0;
          oc_nxt    = found_r ? cext[TW-1:0] : '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          low_nxt   = '0;
          high_nxt  = '0;
          found_nxt = 1'b0;
          bd_nxt    = '0;
          br_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cfg_r    <= mrst_pkg::CFG_RESET;
      cnt_r    <= '0;
      sum_r    <= '0;
      low_r    <= '0;
      high_r   <= '0;
      found_r  <= 1'b0;
      bd_r     <= '0;
      br_r     <= '0;
      ov_r     <= 1'b0;
      pend_r   <= 1'b0;
      sel_v_r  <= 1'b0;
      prev_v_r <= 1'b0;
      taken_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) cfg_r <= cfg_data;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      found_r  <= found_nxt;
      bd_r     <= bd_nxt;
      br_r     <= br_nxt;
      ov_r     <= ov_nxt;
      pend_r   <= pend_nxt;
      sel_v_r  <= sel_v_nxt;
      prev_v_r <= prev_v_nxt;
      taken_r  <= taken_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mid_r   <= mid_nxt;
    idx_r   <= idx_nxt;
    nidx_r  <= nidx_nxt;
    prod_r  <= prod_nxt;
    cidx_r  <= cidx_nxt;
    sel_r   <= sel_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    ru_r    <= ru_nxt;
    rv_r    <= rv_nxt;
    su_r    <= su_nxt;
    sv_r    <= sv_nxt;
    which_r <= which_nxt;
    dsum_r  <= dsum_nxt;
    rsum_r  <= rsum_nxt;
    fprod_r <= fprod_nxt;
    x1_r    <= x1_nxt;
    x2_r    <= x2_nxt;
    oimp_r  <= oimp_nxt;
    og_r    <= og_nxt;
    oc_r    <= oc_nxt;
  end

  assign out_valid           = ov_r;
  assign out_impossible      = oimp_r;
  assign out_best_gain_total = og_r;
  assign out_best_cost_total = oc_r;

  // The search interval never inverts
  a_interval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> low_r <= high_r)
    else $error("ratio interval inverted");

  // A probe never takes more than a spanning tree's edges
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EDEC |-> taken_r <= n1)
    else $error("too many tree edges");

  // A result holds the found flag consistently with its totals
  a_impossible: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oimp_r |-> og_r == '0 && oc_r == '0)
    else $error("impossible result carries totals");

  // Edge count clears once a result is registered
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && state_nxt == S_IDLE |=> cnt_r == '0)
    else $error("edge count not cleared");

endmodule

// File: sim/mrst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_checker
// Watches the edge and result channels of the maximum-ratio spanning tree
// block, predicts each search result from the loaded graph and compares it.
// ----------------------------------------------------------------------------
module mrst_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mrst_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [mrst_pkg::END_W-1:0] in_end_a,
  input  logic [mrst_pkg::END_W-1:0] in_end_b,
  input  logic [mrst_pkg::WT_W-1:0]  in_gain_weight,
  input  logic [mrst_pkg::WT_W-1:0]  in_cost_weight,
  input  logic                       in_last_edge,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_impossible,
  input  logic [mrst_pkg::TOT_W-1:0] out_best_gain_total,
  input  logic [mrst_pkg::TOT_W-1:0] out_best_cost_total,
  output int                         errors,
  output int                         pending,
  output int                         checked
);

  localparam int NODES = mrst_pkg::DEF_MAX_NODES;
  localparam int EDGES = mrst_pkg::DEF_MAX_EDGES;
  localparam int FB    = mrst_pkg::DEF_FRAC_BITS;
  localparam int TOT_W = mrst_pkg::TOT_W;
  localparam int CFG_W = mrst_pkg::CFG_W;

  typedef struct {
    bit               impossible;
    logic [TOT_W-1:0] gain_total;
    logic [TOT_W-1:0] cost_total;
  } tree_result_t;

  mrst_pkg::edge_t  graph_edges [EDGES];
  int               edge_cnt;
  logic [CFG_W-1:0] node_cfg;
  longint           edge_key [EDGES];
  int               order [EDGES];
  int               uf_parent [NODES];
  int               uf_size [NODES];
  tree_result_t     expected_trees [$];

  // Descending key, then smaller d, larger r, larger a, larger b
  function automatic bit ranks_ahead(int i, int j);
    if (edge_key[i] != edge_key[j]) return edge_key[i] > edge_key[j];
    if (graph_edges[i].d != graph_edges[j].d) return graph_edges[i].d < graph_edges[j].d;
    if (graph_edges[i].r != graph_edges[j].r) return graph_edges[i].r > graph_edges[j].r;
    if (graph_edges[i].a != graph_edges[j].a) return graph_edges[i].a > graph_edges[j].a;
    return graph_edges[i].b > graph_edges[j].b;
  endfunction

  function automatic int find_root(int v);
    int k;
    for (k = 0; k < NODES && uf_parent[v] != v; k++) v = uf_parent[v] % NODES;
    return v;
  endfunction

  // One Kruskal pass at ratio mid; returns feasibility and the tree totals
  function automatic bit kruskal_probe(longint unsigned mid, int n,
                                       output longint unsigned dsum,
                                       output longint unsigned rsum);
    int i, j, x, e, u, v, t, taken;
    taken = 0;
    dsum = 0;
    rsum = 0;
    for (i = 0; i < edge_cnt; i++) begin
      edge_key[i] = longint'(longint'(graph_edges[i].d) << FB)
                    - longint'(mid * longint'(graph_edges[i].r));
      order[i] = i;
    end
    for (i = 1; i < edge_cnt; i++) begin
      x = order[i];
      j = i;
      while (j > 0 && ranks_ahead(x, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = x;
    end
    for (i = 0; i < n; i++) begin
      uf_parent[i] = i;
      uf_size[i] = 1;
    end
    for (i = 0; i < edge_cnt && taken < n - 1; i++) begin
      e = order[i];
      if (graph_edges[e].a >= n || graph_edges[e].b >= n) continue;
      u = find_root(graph_edges[e].a);
      v = find_root(graph_edges[e].b);
      if (u == v) continue;
      if (uf_size[u] < uf_size[v]) begin
        t = u; u = v; v = t;
      end
      uf_parent[v] = u;
      uf_size[u] += uf_size[v];
      dsum += graph_edges[e].d;
      rsum += graph_edges[e].r;
      taken++;
    end
    return taken == n - 1 && (dsum << FB) >= mid * rsum;
  endfunction

  // Binary search on the ratio, keeping the best tree by cross-multiplying
  function automatic tree_result_t best_ratio_tree();
    tree_result_t     res;
    longint unsigned  sum_r, lo, hi, mid, dd, rr, best_d, best_r;
    bit               found;
    int               n, i;
    n = (node_cfg < mrst_pkg::MIN_NODES) ? mrst_pkg::MIN_NODES :
        (node_cfg > NODES) ? NODES : node_cfg;
    sum_r = 0;
    for (i = 0; i < edge_cnt; i++) sum_r += graph_edges[i].r;
    lo = 0;
    hi = (sum_r << FB) >> 1;
    found = 0;
    best_d = 0;
    best_r = 0;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (kruskal_probe(mid, n, dd, rr)) begin
        lo = mid;
        if (!found || dd * best_r > best_d * rr) begin
          found = 1;
          best_d = dd;
          best_r = rr;
        end
      end else begin
        hi = mid;
      end
    end
    res.impossible = !found;
    res.gain_total = found ? best_d[TOT_W-1:0] : '0;
    res.cost_total = found ? best_r[TOT_W-1:0] : '0;
    return res;
  endfunction

  assign pending = expected_trees.size();

  always @(posedge clk) begin
    tree_result_t exp_tree;
    int           miss;
    miss = 0;
    if (!rst_n) begin
      edge_cnt = 0;
      node_cfg <= mrst_pkg::CFG_RESET;
      errors   <= 0;
      checked  <= 0;
      expected_trees.delete();
    end else begin
      // Track the node count register
      if (cfg_we) node_cfg <= cfg_data;
      // Load the edge; the last one closes the graph and predicts its tree
      if (in_valid && in_ready) begin
        if (edge_cnt < EDGES) begin
          graph_edges[edge_cnt] = '{a: in_end_a, b: in_end_b,
                                    d: in_gain_weight, r: in_cost_weight};
          edge_cnt = edge_cnt + 1;
        end
        if (in_last_edge) begin
          expected_trees.push_back(best_ratio_tree());
          edge_cnt = 0;
        end
      end
      // Compare the result item with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_trees.size() == 0) begin
          $error("result item with no prediction waiting");
          miss = miss + 1;
        end else begin
          exp_tree = expected_trees.pop_front();
          checked <= checked + 1;
          if (out_impossible !== exp_tree.impossible) begin
            $error("impossible: expected %0d, got %0d", exp_tree.impossible, out_impossible);
            miss = miss + 1;
          end
          if (out_best_gain_total !== exp_tree.gain_total) begin
            $error("best_gain_total: expected %0d, got %0d",
                   exp_tree.gain_total, out_best_gain_total);
            miss = miss + 1;
          end
          if (out_best_cost_total !== exp_tree.cost_total) begin
            $error("best_cost_total: expected %0d, got %0d",
                   exp_tree.cost_total, out_best_cost_total);
            miss = miss + 1;
          end
        end
      end
      errors <= errors + miss;
    end
  end
endmodule

// File: sim/max_ratio_spanning_tree_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_ratio_spanning_tree_tb
// Feeds directed and random graphs to the spanning tree search under random
// stalls on both channels and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module max_ratio_spanning_tree_tb;

  localparam int ITEM_GOAL  = 1850;
  localparam int STALL_LIMIT = 1000000;
  localparam int END_W = mrst_pkg::END_W;
  localparam int WT_W  = mrst_pkg::WT_W;
  localparam int TOT_W = mrst_pkg::TOT_W;
  localparam int CFG_W = mrst_pkg::CFG_W;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             cfg_we = 0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 0;
  logic             in_ready;
  logic [END_W-1:0] in_end_a = '0;
  logic [END_W-1:0] in_end_b = '0;
  logic [WT_W-1:0]  in_gain_weight = '0;
  logic [WT_W-1:0]  in_cost_weight = '0;
  logic             in_last_edge = 0;
  logic             out_valid;
  logic             out_ready = 0;
  logic             out_impossible;
  logic [TOT_W-1:0] out_best_gain_total;
  logic [TOT_W-1:0] out_best_cost_total;

  int errors, pending, checked;
  int edges_sent = 0;
  int graphs_sent = 0;
  int quiet_cycles = 0;
  bit in_taken = 0;
  bit calm = 0;
  bit hold_results = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  max_ratio_spanning_tree dut (.*);

  mrst_checker u_checker (.*);

  // Note acceptance at the edge, read by the driver at the next falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, none in the calm stretch, never ready during a hold
  always @(negedge clk) begin
    if (!rst_n || hold_results) begin
      out_ready <= 0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  // Hold off the receiver once for a long stretch while edges keep coming
  initial begin
    wait (edges_sent >= 300);
    hold_results = 1;
    repeat (3000) @(negedge clk);
    hold_results = 0;
  end

  // Offer one edge and hold it until accepted
  task automatic send_edge(int a, int b, int d, int r, bit last);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid       <= 1;
    in_end_a       <= END_W'(a);
    in_end_b       <= END_W'(b);
    in_gain_weight <= WT_W'(d);
    in_cost_weight <= WT_W'(r);
    in_last_edge   <= last;
    do @(negedge clk); while (!in_taken);
    edges_sent++;
    if (last) graphs_sent++;
  endtask

  // Write the node count once the block has drained
  task automatic set_nodes(int n);
    in_valid <= 0;
    wait (pending == 0);
    repeat (12) @(negedge clk);
    cfg_we   <= 1;
    cfg_data <= CFG_W'(n);
    @(negedge clk);
    cfg_we   <= 0;
  endtask

  function automatic int rand_weight();
    return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(1, 255);
  endfunction

  // Random graph: a random spanning tree, then extra edges
  task automatic send_graph(int n, int extra, bit noisy);
    int i, a, b, total;
    total = n - 1 + extra;
    for (i = 0; i < total; i++) begin
      if (i < n - 1) begin
        a = i + 1;
        b = $urandom_range(0, i);
      end else begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end
      if (noisy && $urandom_range(0, 9) == 0) a = $urandom_range(0, 63);
      if ($urandom_range(0, 1) != 0) send_edge(b, a, rand_weight(), rand_weight(), i == total - 1);
      else send_edge(a, b, rand_weight(), rand_weight(), i == total - 1);
    end
  endtask

  initial begin
    int n, i;
    repeat (5) @(negedge clk);
    rst_n <= 1;

    // Directed: weight extremes, zero cost, empty interval, self loop
    set_nodes(2);
    send_edge(0, 1, 65535, 65535, 1);
    send_edge(1, 0, 0, 1, 1);
    send_edge(1, 0, 5, 0, 1);
    send_edge(1, 1, 3, 4, 1);
    // Node count below the minimum acts as two
    set_nodes(0);
    send_edge(0, 1, 7, 9, 1);
    set_nodes(1);
    send_edge(1, 0, 65535, 1, 1);
    // Out-of-range endpoint and tied keys
    set_nodes(3);
    send_edge(0, 1, 10, 2, 0);
    send_edge(1, 2, 3, 8, 0);
    send_edge(2, 1, 3, 8, 0);
    send_edge(2, 5, 100, 1, 0);
    send_edge(0, 2, 10, 2, 1);
    // Node count above the maximum acts as the maximum; top endpoint bits
    set_nodes(127);
    send_edge(63, 62, 1234, 4321, 0);
    send_edge(0, 63, 65535, 0, 1);
    set_nodes(4);
    send_edge(0, 1, 6, 3, 0);
    send_edge(1, 2, 4, 2, 0);
    send_edge(2, 3, 2, 1, 0);
    send_edge(3, 0, 6, 3, 0);
    send_edge(0, 2, 4, 2, 1);

    // Random graphs, one largest graph and one overflowing edge store
    while (edges_sent < ITEM_GOAL) begin
      if (graphs_sent % 4 == 0) begin
        case ($urandom_range(0, 9))
          0: n = $urandom_range(0, 1);
          1: n = $urandom_range(65, 127);
          default: n = $urandom_range(2, 8);
        endcase
        set_nodes(n);
      end
      calm = (edges_sent >= 900 && edges_sent < 1150);
      if (graphs_sent == 60) begin
        set_nodes(64);
        send_graph(64, 6, 0);
        set_nodes(n);
      end else if (graphs_sent == 120) begin
        set_nodes(2);
        for (i = 0; i < 262; i++)
          send_edge($urandom_range(0, 1), $urandom_range(0, 1), rand_weight(),
                    rand_weight(), i == 261);
        set_nodes(n);
      end else begin
        n = (n < 2) ? 2 : (n > 8) ? 8 : n;
        send_graph(n, $urandom_range(0, 4), $urandom_range(0, 3) == 0);
      end
    end
    in_valid <= 0;
    calm = 0;

    // Drain and settle
    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d edges in %0d graphs; %0d tree results checked.",
             edges_sent, graphs_sent, checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
